// ===== rtl/weighted_server_task_assigner_unit_assert.svh =====
// Assertion macros used by the weighted server task assigner RTL.
`ifndef WEIGHTED_SERVER_TASK_ASSIGNER_UNIT_ASSERT_SVH
`define WEIGHTED_SERVER_TASK_ASSIGNER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsta_pkg.sv =====
// Shared types and constants of the weighted server task assigner.
package wsta_pkg;

    localparam int TIME_W       = 48;
    localparam int TICK_W       = 32;
    localparam int WEIGHT_W     = 16;
    localparam int DUR_W        = 16;
    localparam int IDX_W        = 3;
    localparam int SERVER_COUNT_DEF = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // Record that travels down the row of server cells.
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   now0;
        logic                b_valid;
        logic [IDX_W-1:0]    b_idx;
        logic [WEIGHT_W-1:0] b_w;
        logic                e_valid;
        logic [TIME_W-1:0]   e_time;
        logic [IDX_W-1:0]    e_idx;
        logic [WEIGHT_W-1:0] e_w;
    } t_carry;

    // Free time write-back to the winning cell.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] value;
    } t_wr;

    // Weight register write.
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] data;
    } t_cfg;

endpackage

// ===== rtl/wsta_cell.sv =====
// One server cell: holds the server's weight and free time and refines the scan record.
module wsta_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsta_pkg::t_cfg   i_cfg,
    input  wsta_pkg::t_wr    i_wr,
    input  wsta_pkg::t_carry i_carry,
    output wsta_pkg::t_carry o_carry
);

    localparam int IW = wsta_pkg::IDX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [wsta_pkg::WEIGHT_W-1:0] r_weight;
    logic [wsta_pkg::TIME_W-1:0]   r_free;
    logic                          r_valid;
    wsta_pkg::t_carry              r_data;
    wsta_pkg::t_carry              n_data;

    logic w_is_free;
    logic w_take_b;
    logic w_take_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
            r_free   <= '0;
        end else begin
            if (i_cfg.en && i_cfg.idx == MY_IDX) begin
                r_weight <= i_cfg.data;
            end
            if (i_wr.en && i_wr.idx == MY_IDX) begin
                r_free <= i_wr.value;
            end
        end
    end

    // A free server competes on weight; the earliest-free candidate is kept as a fallback
    // for the case where no server is free at the nominal start time.
    always_comb begin
        w_is_free = (r_free <= i_carry.now0);
        w_take_b  = w_is_free && (!i_carry.b_valid || r_weight < i_carry.b_w);
        w_take_e  = !i_carry.e_valid || (r_free < i_carry.e_time) ||
                    (r_free == i_carry.e_time && r_weight < i_carry.e_w);
        n_data         = i_carry;
        n_data.b_valid = i_carry.b_valid | w_is_free;
        n_data.e_valid = 1'b1;
        if (w_take_b) begin
            n_data.b_idx = MY_IDX;
            n_data.b_w   = r_weight;
        end
        if (w_take_e) begin
            n_data.e_time = r_free;
            n_data.e_idx  = MY_IDX;
            n_data.e_w    = r_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_carry.valid;
        end
    end

    // Record data holds after the token has moved on.
    always_ff @(posedge i_clk) begin
        if (i_carry.valid) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_carry       = r_data;
        o_carry.valid = r_valid;
    end

endmodule

// ===== rtl/weighted_server_task_assigner_unit.sv =====
// Top level of the weighted server task assigner: control, time keeping and result register.
// An accepted transaction's scan record passes through the register of each server cell in turn;
// the winner's free time is then written back and the result is loaded into the output register.
// A new transaction is accepted only after the previous one has been written back.
// A full output register stalls the write-back until the result is taken.
// Synchronous active-low reset clears all weights, free times, the tick counter and start time.
`include "weighted_server_task_assigner_unit_assert.svh"

module weighted_server_task_assigner_unit #(
    parameter int SERVER_COUNT = wsta_pkg::SERVER_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wsta_pkg::DUR_W-1:0]    i_task_duration,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wsta_pkg::IDX_W-1:0]    o_server_index,
    input  logic                          i_cfg_we,
    input  logic [wsta_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [wsta_pkg::WEIGHT_W-1:0] i_cfg_data
);

    localparam int TW = wsta_pkg::TIME_W;
    localparam int KW = wsta_pkg::TICK_W;
    localparam int DW = wsta_pkg::DUR_W;

    // Control state.
    wsta_pkg::t_state r_state;
    wsta_pkg::t_state n_state;

    // Tick of the next arriving transaction and start time of the last one.
    logic [KW-1:0] r_tick;
    logic [TW-1:0] r_start;
    logic [DW-1:0] r_dur;

    // Result register that decouples the write-back from the consumer.
    logic                       r_out_valid;
    logic [wsta_pkg::IDX_W-1:0] r_out_idx;

    wsta_pkg::t_carry w_chain [0:SERVER_COUNT];
    wsta_pkg::t_carry w_last;
    wsta_pkg::t_cfg   w_cfg;
    wsta_pkg::t_wr    w_wr;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_fire;
    logic [TW-1:0]              w_now0;
    logic [TW-1:0]              w_now;
    logic [wsta_pkg::IDX_W-1:0] w_best;
    logic [TW:0]                w_sum;
    logic [TW-1:0]              w_new_free;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = w_chain[SERVER_COUNT];

    // Nominal start: the later of the arrival tick and the previous start.
    always_comb begin
        if (TW'(r_tick) > r_start) begin
            w_now0 = TW'(r_tick);
        end else begin
            w_now0 = r_start;
        end
    end

    // The scan record enters the first cell in the cycle the transaction is accepted.
    always_comb begin
        w_chain[0]         = '0;
        w_chain[0].valid   = w_accept;
        w_chain[0].now0    = w_now0;
        w_chain[0].e_time  = '1;
    end

    assign w_cfg.en   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_index;
    assign w_cfg.data = i_cfg_data;

    genvar g;
    generate
        for (g = 0; g < SERVER_COUNT; g++) begin : g_cell
            wsta_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (w_cfg),
                .i_wr    (w_wr),
                .i_carry (w_chain[g]),
                .o_carry (w_chain[g+1])
            );
        end
    endgenerate

    // Winner selection: if some server was free at the nominal start it wins on weight;
    // otherwise time advances to the earliest free time and that group competes on weight.
    always_comb begin
        if (w_last.b_valid) begin
            w_now  = w_last.now0;
            w_best = w_last.b_idx;
        end else begin
            w_now  = w_last.e_time;
            w_best = w_last.e_idx;
        end
        w_sum = {1'b0, w_now} + (TW + 1)'(r_dur);
        if (w_sum[TW]) begin
            w_new_free = '1;
        end else begin
            w_new_free = w_sum[TW-1:0];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsta_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = wsta_pkg::ST_SCAN;
                end
            end
            wsta_pkg::ST_SCAN: begin
                if (w_last.valid) begin
                    n_state = w_out_free ? wsta_pkg::ST_IDLE : wsta_pkg::ST_WAIT;
                end
            end
            wsta_pkg::ST_WAIT: begin
                if (w_out_free) begin
                    n_state = wsta_pkg::ST_IDLE;
                end
            end
            default: n_state = wsta_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the state machine.
    always_comb begin
        o_ready = 1'b0;
        w_fire  = 1'b0;
        unique case (r_state)
            wsta_pkg::ST_IDLE: o_ready = 1'b1;
            wsta_pkg::ST_SCAN: w_fire  = w_last.valid && w_out_free;
            wsta_pkg::ST_WAIT: w_fire  = w_out_free;
            default: begin
                o_ready = 1'b0;
                w_fire  = 1'b0;
            end
        endcase
    end

    assign w_wr.en    = w_fire;
    assign w_wr.idx   = w_best;
    assign w_wr.value = w_new_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsta_pkg::ST_IDLE;
            r_tick      <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && r_tick != '1) begin
                r_tick <= r_tick + KW'(1);
            end
            if (w_fire) begin
                r_start     <= w_now;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dur <= i_task_duration;
        end
        if (w_fire) begin
            r_out_idx <= w_best;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_server_index = r_out_idx;

    // The scan never leaves the last cell while the block is ready for a new transaction.
    `WSTA_ASSERT_IMP(a_idle_chain_empty, i_clk, i_rst_n, o_ready, !w_last.valid, "scan record at end while idle")
    // A write-back happens only while a scan result is pending.
    `WSTA_ASSERT_IMP(a_fire_busy, i_clk, i_rst_n, w_fire, r_state != wsta_pkg::ST_IDLE, "write-back while idle")
    // Accepting a transaction closes the input until its result is written back.
    `WSTA_ASSERT_NXT(a_accept_closes, i_clk, i_rst_n, w_accept, !o_ready, "ready high right after accept")
    // Every write-back presents a result in the next cycle.
    `WSTA_ASSERT_NXT(a_fire_result, i_clk, i_rst_n, w_fire, o_valid, "write-back without result")
    // Results only name servers of the pool.
    `WSTA_ASSERT_IMP(a_index_range, i_clk, i_rst_n, o_valid, 32'(o_server_index) < SERVER_COUNT, "server index out of pool")

endmodule
